/* src/dss_pkg.sv */
// Shared types and codes for the dual stack shared store block.
// No dependencies; used by dss_front, dss_back and the top level.
package dss_pkg;

    // Request codes on req_type (A on even codes, B on odd codes)
    typedef enum logic [2:0] {
        REQ_PUSH_A = 3'd0,
        REQ_PUSH_B = 3'd1,
        REQ_POP_A  = 3'd2,
        REQ_POP_B  = 3'd3,
        REQ_LIST_A = 3'd4,
        REQ_LIST_B = 3'd5
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_LIST = 2'd2
    } op_t;

    // Stack selector
    typedef enum logic {
        SIDE_A = 1'b0,
        SIDE_B = 1'b1
    } side_t;

    typedef struct packed {
        op_t         op;
        side_t       side;
        logic [31:0] value;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_LIST = 1'b1
    } back_state_t;

    localparam int QUEUE_DEPTH = 2;

endpackage

/* src/dual_stack_shared_store_core.sv */
// Top level of the dual stack shared store block.
// Depends on dss_pkg, dss_front and dss_back.
//
//  channel   | handshake            | words
//  ----------+----------------------+-----------------------------
//  request   | start high, busy low | req_type, push_value
//  result    | strobe, one cycle    | status, data, last
//
// Push, pop and error results are registered in the back end as it takes each queued command.
// A list of n entries streams n results on consecutive cycles, one store read each,
// once the back end enters its list state; the single store read port sets that rate.
// A pending read result holds the next command back. Reset empties both stacks.
// A two-entry command queue takes new requests while the back end works;
// busy rises only when that queue is full; the receiver cannot stall.
module dual_stack_shared_store_core #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] push_value,
    output logic               busy,
    output logic               strobe,
    output logic [1:0]         status,
    output logic signed [31:0] data,
    output logic               last
);
    import dss_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // Accept and classify
    dss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .push_value(push_value),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Execute against the store
    dss_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop),
        .strobe   (strobe),
        .status   (status),
        .data     (data),
        .last     (last)
    );

endmodule

/* src/dss_front.sv */
// Front end: accepts requests, classifies them and queues commands.
// Depends on dss_pkg.
module dss_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] push_value,
    output logic               busy,
    output logic               cmd_valid,
    output dss_pkg::cmd_t      cmd,
    input  logic               cmd_pop
);
    import dss_pkg::*;

    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       accept;
    logic       known;
    cmd_t       cls;

    // Classify the incoming request; unused codes are dropped
    always_comb
    begin
        known     = 1'b1;
        cls.op    = OP_PUSH;
        cls.side  = req_type[0] ? SIDE_B : SIDE_A;
        cls.value = push_value;
        unique case (req_type)
            REQ_PUSH_A, REQ_PUSH_B: cls.op = OP_PUSH;
            REQ_POP_A,  REQ_POP_B:  cls.op = OP_POP;
            REQ_LIST_A, REQ_LIST_B: cls.op = OP_LIST;
            default:                known  = 1'b0;
        endcase
    end

    assign busy      = (fill_reg == 2'(QUEUE_DEPTH));
    assign accept    = start && !busy;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    // Advance queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (accept && known)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        fill_next = fill_reg + 2'(accept && known) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (accept && known)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'(QUEUE_DEPTH))
        else $error("queue fill level out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");
    a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !known && !cmd_pop) |=> $stable(fill_reg))
        else $error("unused request code entered the queue");
`endif

endmodule

/* src/dss_back.sv */
// Back end: executes queued commands against the shared word store.
// Depends on dss_pkg; holds the store, both stack counts and the list walker.
module dss_back #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  dss_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               strobe,
    output logic [1:0]         status,
    output logic signed [31:0] data,
    output logic               last
);
    import dss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [31:0]   mem [DEPTH];

    back_state_t   state_reg, state_next;
    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] left_reg, left_next;
    side_t         side_reg, side_next;
    logic          imm_valid_reg, imm_valid_next;
    status_t       imm_status_reg, imm_status_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_last_reg, rd_last_next;
    logic [31:0]   rd_q_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          full;
    logic          empty_sel;
    logic [CW-1:0] count_sel;

    assign full      = ({1'b0, count_a_reg} + {1'b0, count_b_reg}) >= {1'b0, DEPTH_C};
    assign count_sel = (cmd.side == SIDE_B) ? count_b_reg : count_a_reg;
    assign empty_sel = (count_sel == '0);

    // Decode commands and walk lists
    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        side_next       = side_reg;
        imm_valid_next  = 1'b0;
        imm_status_next = ST_OK;
        rd_pend_next    = 1'b0;
        rd_last_next    = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        cmd_pop         = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && !rd_pend_reg)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_PUSH:
                        begin
                            imm_valid_next = 1'b1;
                            if (full)
                            begin
                                imm_status_next = ST_OVERFLOW;
                            end
                            else if (cmd.side == SIDE_B)
                            begin
                                mem_we       = 1'b1;
                                mem_waddr    = AW'(DEPTH_C - count_b_reg - CW'(1));
                                count_b_next = count_b_reg + CW'(1);
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                mem_waddr    = AW'(count_a_reg);
                                count_a_next = count_a_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (empty_sel)
                            begin
                                imm_valid_next  = 1'b1;
                                imm_status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                mem_re       = 1'b1;
                                rd_pend_next = 1'b1;
                                rd_last_next = 1'b1;
                                if (cmd.side == SIDE_B)
                                begin
                                    mem_raddr    = AW'(DEPTH_C - count_b_reg);
                                    count_b_next = count_b_reg - CW'(1);
                                end
                                else
                                begin
                                    mem_raddr    = AW'(count_a_reg - CW'(1));
                                    count_a_next = count_a_reg - CW'(1);
                                end
                            end
                        end
                        OP_LIST:
                        begin
                            if (empty_sel)
                            begin
                                imm_valid_next  = 1'b1;
                                imm_status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                state_next = BK_LIST;
                                side_next  = cmd.side;
                                left_next  = count_sel;
                                ptr_next   = (cmd.side == SIDE_B) ?
                                             AW'(DEPTH_C - count_b_reg) :
                                             AW'(count_a_reg - CW'(1));
                            end
                        end
                        default:
                        begin
                            imm_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            BK_LIST:
            begin
                mem_re       = 1'b1;
                mem_raddr    = ptr_reg;
                rd_pend_next = 1'b1;
                rd_last_next = (left_reg == CW'(1));
                left_next    = left_reg - CW'(1);
                ptr_next     = (side_reg == SIDE_B) ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
                if (left_reg == CW'(1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            left_reg       <= '0;
            side_reg       <= SIDE_A;
            imm_valid_reg  <= 1'b0;
            imm_status_reg <= ST_OK;
            rd_pend_reg    <= 1'b0;
            rd_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            left_reg       <= left_next;
            side_reg       <= side_next;
            imm_valid_reg  <= imm_valid_next;
            imm_status_reg <= imm_status_next;
            rd_pend_reg    <= rd_pend_next;
            rd_last_reg    <= rd_last_next;
        end
    end

    // Hold the walk pointer
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
    end

    // Word store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.value;
        end
        if (mem_re)
        begin
            rd_q_reg <= mem[mem_raddr];
        end
    end

    // Drive the result word
    assign strobe = imm_valid_reg | rd_pend_reg;
    assign status = rd_pend_reg ? 2'(ST_OK) : 2'(imm_status_reg);
    assign data   = rd_pend_reg ? $signed(rd_q_reg) : 32'sd0;
    assign last   = rd_pend_reg ? rd_last_reg : 1'b1;

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_a_reg} + {1'b0, count_b_reg}) <= {1'b0, DEPTH_C})
        else $error("stacks overlap in the store");
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(imm_valid_reg && rd_pend_reg))
        else $error("two result sources in one cycle");
    a_list_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("list results not contiguous");
    a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LIST) |-> (left_reg != '0))
        else $error("list walk with nothing left");
`endif

endmodule

/* verif/dss_stack_checker.sv */
`timescale 1ns / 100ps
// Checker for the dual stack shared store: predicts and compares every result word.
// Depends on dss_pkg; instantiated by dual_stack_shared_store_core_tb.
module dss_stack_checker #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] push_value,
    input  logic               strobe,
    input  logic [1:0]         status,
    input  logic signed [31:0] data,
    input  logic               last,
    output int                 fail_count,
    output int                 words_due,
    output int                 requests_taken,
    output int                 results_checked,
    output int                 overflow_count,
    output int                 underflow_count
);
    import dss_pkg::*;

    typedef struct {
        status_t     st;
        logic [31:0] word;
        logic        tail;
    } result_word_t;

    // Shadow copy of the shared store and both stack heights
    logic [31:0]  shadow_store [DEPTH];
    int unsigned  depth_a;
    int unsigned  depth_b;
    result_word_t due_q [$];

    function automatic result_word_t make_word(status_t st, logic [31:0] word, logic tail);
        result_word_t r;
        r.st   = st;
        r.word = word;
        r.tail = tail;
        return r;
    endfunction

    // Update the shadow stacks and queue the words this request must produce
    task automatic apply_request(input logic [2:0] code, input logic [31:0] value);
        int unsigned i;
        case (code)
            REQ_PUSH_A, REQ_PUSH_B:
            begin
                if (depth_a + depth_b >= DEPTH)
                begin
                    due_q.push_back(make_word(ST_OVERFLOW, '0, 1'b1));
                end
                else
                begin
                    if (code == REQ_PUSH_A)
                    begin
                        shadow_store[depth_a] = value;
                        depth_a++;
                    end
                    else
                    begin
                        depth_b++;
                        shadow_store[DEPTH - depth_b] = value;
                    end
                    due_q.push_back(make_word(ST_OK, '0, 1'b1));
                end
            end
            REQ_POP_A:
            begin
                if (depth_a == 0)
                begin
                    due_q.push_back(make_word(ST_UNDERFLOW, '0, 1'b1));
                end
                else
                begin
                    depth_a--;
                    due_q.push_back(make_word(ST_OK, shadow_store[depth_a], 1'b1));
                end
            end
            REQ_POP_B:
            begin
                if (depth_b == 0)
                begin
                    due_q.push_back(make_word(ST_UNDERFLOW, '0, 1'b1));
                end
                else
                begin
                    due_q.push_back(make_word(ST_OK, shadow_store[DEPTH - depth_b], 1'b1));
                    depth_b--;
                end
            end
            REQ_LIST_A:
            begin
                if (depth_a == 0)
                begin
                    due_q.push_back(make_word(ST_UNDERFLOW, '0, 1'b1));
                end
                else
                begin
                    // top of A first, bottom entry carries last
                    for (i = depth_a; i > 0; i--)
                    begin
                        due_q.push_back(make_word(ST_OK, shadow_store[i - 1], i == 1));
                    end
                end
            end
            REQ_LIST_B:
            begin
                if (depth_b == 0)
                begin
                    due_q.push_back(make_word(ST_UNDERFLOW, '0, 1'b1));
                end
                else
                begin
                    // top of B sits at the low index, bottom at the store's high end
                    for (i = DEPTH - depth_b; i < DEPTH; i++)
                    begin
                        due_q.push_back(make_word(ST_OK, shadow_store[i], i == DEPTH - 1));
                    end
                end
            end
            default:
            begin
                // unused request codes: no word, no change
            end
        endcase
    endtask

    // Compare result words against the oldest prediction, then take new requests
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        int           errs;
        if (!rst_n)
        begin
            due_q.delete();
            depth_a = 0;
            depth_b = 0;
            fail_count      <= 0;
            words_due       <= 0;
            requests_taken  <= 0;
            results_checked <= 0;
            overflow_count  <= 0;
            underflow_count <= 0;
        end
        else
        begin
            errs = 0;
            if (strobe)
            begin
                if (due_q.size() == 0)
                begin
                    $error("unexpected result word: status %0d data %h last %0b",
                           status, data, last);
                    errs++;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        errs++;
                    end
                    if (data !== want.word)
                    begin
                        $error("data: expected %h, got %h", want.word, data);
                        errs++;
                    end
                    if (last !== want.tail)
                    begin
                        $error("last: expected %0b, got %0b", want.tail, last);
                        errs++;
                    end
                end
                results_checked <= results_checked + 1;
                if (status == ST_OVERFLOW)
                    overflow_count <= overflow_count + 1;
                if (status == ST_UNDERFLOW)
                    underflow_count <= underflow_count + 1;
            end
            if (start && !busy)
            begin
                apply_request(req_type, push_value);
                requests_taken <= requests_taken + 1;
            end
            fail_count <= fail_count + errs;
            words_due  <= due_q.size();
        end
    end

endmodule

/* verif/dual_stack_shared_store_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top for dual_stack_shared_store_core: drives requests, gives the verdict.
// Depends on dss_pkg, the core RTL and dss_stack_checker.
module dual_stack_shared_store_core_tb;
    import dss_pkg::*;

    localparam int         DEPTH        = 16;
    localparam int         RANDOM_WORDS = 340;
    localparam logic [2:0] REQ_SPARE_6  = 3'd6;
    localparam logic [2:0] REQ_SPARE_7  = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [2:0]         req_type;
    logic signed [31:0] push_value;
    logic               busy;
    logic               strobe;
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;

    int fail_count;
    int words_due;
    int requests_taken;
    int results_checked;
    int overflow_count;
    int underflow_count;
    int idle_pct;

    dual_stack_shared_store_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .push_value(push_value),
        .busy      (busy),
        .strobe    (strobe),
        .status    (status),
        .data      (data),
        .last      (last)
    );

    dss_stack_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .push_value     (push_value),
        .strobe         (strobe),
        .status         (status),
        .data           (data),
        .last           (last),
        .fail_count     (fail_count),
        .words_due      (words_due),
        .requests_taken (requests_taken),
        .results_checked(results_checked),
        .overflow_count (overflow_count),
        .underflow_count(underflow_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #3_000_000;
        $error("run timed out with %0d result words outstanding", words_due);
        $display("*** FAILED ***");
        $finish;
    end

    // Bias toward the extremes of the word range
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Draw a request code from the current push and side bias
    function automatic logic [2:0] pick_request(int push_pct, int a_pct);
        int   roll;
        logic side_b;
        roll   = $urandom_range(99);
        side_b = ($urandom_range(99) >= a_pct);
        if (roll < 3)
            return $urandom_range(1) ? REQ_SPARE_7 : REQ_SPARE_6;
        if (roll < 13)
            return side_b ? REQ_LIST_B : REQ_LIST_A;
        if (roll < 13 + (87 * push_pct) / 100)
            return side_b ? REQ_PUSH_B : REQ_PUSH_A;
        return side_b ? REQ_POP_B : REQ_POP_A;
    endfunction

    // Hold the word until busy is low at an edge, then idle at random
    task automatic send_request(input logic [2:0] code, input logic [31:0] value);
        start      <= 1'b1;
        req_type   <= code;
        push_value <= value;
        do
            @(posedge clk);
        while (busy);
        while ($urandom_range(99) < idle_pct)
        begin
            start      <= 1'b0;
            req_type   <= 3'($urandom_range(7));
            push_value <= $urandom;
            @(posedge clk);
        end
    endtask

    initial
    begin
        int         i;
        int         sent;
        int         phase;
        int         push_pct;
        int         a_pct;
        logic [2:0] code;

        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_PUSH_A;
        push_value = '0;
        idle_pct   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty-stack errors and ignored codes
        send_request(REQ_POP_A, 32'h1234_5678);
        send_request(REQ_LIST_B, 32'h0);
        send_request(REQ_SPARE_6, 32'hFFFF_FFFF);
        send_request(REQ_SPARE_7, 32'h0);

        // Extreme words, then fill the store from both ends
        send_request(REQ_PUSH_A, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_B, 32'h8000_0000);
        send_request(REQ_PUSH_A, 32'hFFFF_FFFF);
        send_request(REQ_PUSH_B, 32'h0000_0000);
        for (i = 4; i < DEPTH; i++)
            send_request(i[0] ? REQ_PUSH_B : REQ_PUSH_A, pick_value());

        // Overflow on both sides, full listings, pops
        send_request(REQ_PUSH_A, 32'h0000_0001);
        send_request(REQ_PUSH_B, 32'hFFFF_FFFE);
        send_request(REQ_LIST_A, 32'h0);
        send_request(REQ_LIST_B, 32'h0);
        send_request(REQ_POP_A, 32'h0);
        send_request(REQ_POP_B, 32'h0);

        // Random traffic under three sender idle patterns
        sent     = 0;
        push_pct = 50;
        a_pct    = 50;
        for (phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 1) ? 82 : (phase == 2) ? 37 : 0;
            while (sent < RANDOM_WORDS * (phase + 1) / 3)
            begin
                // shift the bias now and then so stacks fill, drain and meet
                if ($urandom_range(39) == 0)
                begin
                    case ($urandom_range(2))
                        0:       push_pct = 15;
                        1:       push_pct = 50;
                        default: push_pct = 85;
                    endcase
                    case ($urandom_range(2))
                        0:       a_pct = 10;
                        1:       a_pct = 50;
                        default: a_pct = 90;
                    endcase
                end
                code = pick_request(push_pct, a_pct);
                send_request(code, pick_value());
                if (code != REQ_SPARE_6 && code != REQ_SPARE_7)
                    sent++;
            end
        end

        // Drain outstanding words, then allow for a stray late result
        start <= 1'b0;
        @(posedge clk);
        wait (words_due == 0);
        repeat (40) @(posedge clk);

        $display("Covered %0d requests and %0d result words, %0d overflow and %0d underflow,",
                 requests_taken, results_checked, overflow_count, underflow_count);
        $display("with no idling, 82%% and 37%% sender idling.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
src/dss_pkg.sv
src/dss_front.sv
src/dss_back.sv
src/dual_stack_shared_store_core.sv
verif/dss_stack_checker.sv
verif/dual_stack_shared_store_core_tb.sv
